@@ hw/rtl/bgp_pkg.sv @@
// Shared constants, types and codes for the ground-plane back-projection pipeline.
`default_nettype none

package bgp_pkg;

	localparam int PIXEL_BITS = 12;
	localparam int CFG_W      = 20;
	localparam int ALT_W      = 16;
	localparam int QUAT_W     = 16;
	localparam int POS_W      = 24;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 2;

	localparam int MAT_SHIFT = PIXEL_BITS + 2;
	localparam int RAY_SHIFT = 14;

	// pixel offset from principal point, 1/256 px
	localparam int PIX_SH_W = PIXEL_BITS + 8;
	localparam int DX_W     = ((PIX_SH_W > CFG_W) ? PIX_SH_W : CFG_W) + 1;
	// camera ray components
	localparam int CAM_W    = DX_W + CFG_W;
	localparam int CAM_LO_W = (CAM_W + 1) / 2;
	localparam int CAM_HI_W = CAM_W - CAM_LO_W;
	// rotation matrix entries
	localparam int SQ_W   = 2 * QUAT_W;
	localparam int MRAW_W = SQ_W + 3;
	localparam int ME_W   = MRAW_W - MAT_SHIFT + 1;
	// matrix times ray
	localparam int PLO_W = ME_W + CAM_LO_W + 1;
	localparam int PHI_W = ME_W + CAM_HI_W;
	localparam int PP_W  = ME_W + CAM_W;
	localparam int ACC_W = PP_W + 2;
	localparam int WR_W  = ACC_W - RAY_SHIFT + 1;
	// intersection
	localparam int MAG_W = WR_W;
	localparam int DEN_W = WR_W - 1;
	localparam int MLO_W = (MAG_W + 1) / 2;
	localparam int MHI_W = MAG_W - MLO_W;
	localparam int NUM_W = MAG_W + ALT_W + 1;

	localparam logic [CFG_W-1:0] FOCAL_X_RST  = CFG_W'(128000);
	localparam logic [CFG_W-1:0] FOCAL_Y_RST  = CFG_W'(128000);
	localparam logic [CFG_W-1:0] CENTER_X_RST = CFG_W'(81920);
	localparam logic [CFG_W-1:0] CENTER_Y_RST = CFG_W'(61440);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FOCAL_X,
		REG_FOCAL_Y,
		REG_CENTER_X,
		REG_CENTER_Y
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_OK,
		ST_BAD_ALT,
		ST_PARALLEL,
		ST_UPWARD
	} status_t;

	typedef struct packed {
		logic [PIXEL_BITS-1:0]   pixel_col;
		logic [PIXEL_BITS-1:0]   pixel_row;
		logic [ALT_W-1:0]        altitude_mm;
		logic signed [QUAT_W-1:0] rot_w;
		logic signed [QUAT_W-1:0] rot_x;
		logic signed [QUAT_W-1:0] rot_y;
		logic signed [QUAT_W-1:0] rot_z;
		logic signed [POS_W-1:0] cam_north_mm;
		logic signed [POS_W-1:0] cam_east_mm;
		logic signed [POS_W-1:0] cam_down_mm;
	} in_item_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] point_north_mm;
		logic signed [OUT_W-1:0] point_east_mm;
		logic signed [OUT_W-1:0] point_down_mm;
		logic [1:0]              status;
	} out_item_t;

	// per-item values that ride alongside the ray math
	typedef struct packed {
		logic [ALT_W-1:0]        alt;
		logic signed [POS_W-1:0] cam_n;
		logic signed [POS_W-1:0] cam_e;
		logic signed [POS_W-1:0] cam_d;
	} carry_t;

	typedef struct packed {
		logic signed [WR_W-1:0] wr_n;
		logic signed [WR_W-1:0] wr_e;
		logic signed [WR_W-1:0] wr_z;
		carry_t                 carry;
	} ray_t;

	typedef struct packed {
		status_t                 status;
		logic                    neg_n;
		logic                    neg_e;
		logic signed [POS_W-1:0] cam_n;
		logic signed [POS_W-1:0] cam_e;
		logic signed [OUT_W-1:0] down;
	} div_side_t;

endpackage

`default_nettype wire

@@ hw/rtl/bgp_ray.sv @@
// Pinhole ray, quaternion rotation matrix and world-frame ray (five stages).
`default_nettype none

module bgp_ray
	import bgp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             v_in,
	input  wire in_item_t         item,
	input  wire logic [CFG_W-1:0] focal_x,
	input  wire logic [CFG_W-1:0] focal_y,
	input  wire logic [CFG_W-1:0] center_x,
	input  wire logic [CFG_W-1:0] center_y,
	output logic                  v_out,
	output ray_t                  ray
);

	function automatic logic signed [ME_W-1:0] mat_round(input logic signed [MRAW_W-1:0] m);
		logic signed [MRAW_W-1:0] t;
		t = m + $signed(MRAW_W'(1) << (MAT_SHIFT - 1));
		return ME_W'(t >>> MAT_SHIFT);
	endfunction

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	carry_t carry_s1, carry_s2, carry_s3, carry_s4, carry_s5;

	// stage 1: pixel offsets and quaternion products
	logic signed [DX_W-1:0] dx_s1, dy_s1;
	logic [CFG_W-1:0]       fx_s1, fy_s1;
	logic signed [SQ_W-1:0] ww_s1, xx_s1, yy_s1, zz_s1;
	logic signed [SQ_W-1:0] xy_s1, wz_s1, xz_s1, wy_s1, yz_s1, wx_s1;

	// stage 2: camera ray and rounded matrix
	logic signed [CAM_W-1:0] cam_s2 [3];
	logic signed [ME_W-1:0]  m_s2 [3][3];

	// stage 3: partial products
	logic signed [PLO_W-1:0] plo_s3 [3][3];
	logic signed [PHI_W-1:0] phi_s3 [3][3];

	// stage 4: full products
	logic signed [PP_W-1:0] p_s4 [3][3];

	// stage 5: world ray
	logic signed [WR_W-1:0] wr_s5 [3];

	logic signed [MRAW_W-1:0] mraw [3][3];
	logic signed [ACC_W-1:0]  acc [3];

	always_comb begin
		mraw[0][0] = ww_s1 + xx_s1 - yy_s1 - zz_s1;
		mraw[0][1] = (xy_s1 - wz_s1) <<< 1;
		mraw[0][2] = (xz_s1 + wy_s1) <<< 1;
		mraw[1][0] = (xy_s1 + wz_s1) <<< 1;
		mraw[1][1] = ww_s1 - xx_s1 + yy_s1 - zz_s1;
		mraw[1][2] = (yz_s1 - wx_s1) <<< 1;
		mraw[2][0] = (xz_s1 - wy_s1) <<< 1;
		mraw[2][1] = (yz_s1 + wx_s1) <<< 1;
		mraw[2][2] = ww_s1 - xx_s1 - yy_s1 + zz_s1;
		for (int i = 0; i < 3; i++) begin
			acc[i] = ACC_W'(p_s4[i][0]) + ACC_W'(p_s4[i][1]) + ACC_W'(p_s4[i][2])
				+ $signed(ACC_W'(1) << (RAY_SHIFT - 1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s1 <= v_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			carry_s1 <= '{alt: item.altitude_mm, cam_n: item.cam_north_mm,
				cam_e: item.cam_east_mm, cam_d: item.cam_down_mm};
			dx_s1 <= $signed(DX_W'({item.pixel_col, 8'b0})) - $signed(DX_W'(center_x));
			dy_s1 <= $signed(DX_W'({item.pixel_row, 8'b0})) - $signed(DX_W'(center_y));
			fx_s1 <= focal_x;
			fy_s1 <= focal_y;
			ww_s1 <= item.rot_w * item.rot_w;
			xx_s1 <= item.rot_x * item.rot_x;
			yy_s1 <= item.rot_y * item.rot_y;
			zz_s1 <= item.rot_z * item.rot_z;
			xy_s1 <= item.rot_x * item.rot_y;
			wz_s1 <= item.rot_w * item.rot_z;
			xz_s1 <= item.rot_x * item.rot_z;
			wy_s1 <= item.rot_w * item.rot_y;
			yz_s1 <= item.rot_y * item.rot_z;
			wx_s1 <= item.rot_w * item.rot_x;

			carry_s2  <= carry_s1;
			cam_s2[0] <= dx_s1 * $signed({1'b0, fy_s1});
			cam_s2[1] <= dy_s1 * $signed({1'b0, fx_s1});
			cam_s2[2] <= $signed(CAM_W'(fx_s1) * CAM_W'(fy_s1));
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					m_s2[i][j] <= mat_round(mraw[i][j]);
				end
			end

			carry_s3 <= carry_s2;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					plo_s3[i][j] <= m_s2[i][j] * $signed({1'b0, cam_s2[j][CAM_LO_W-1:0]});
					phi_s3[i][j] <= m_s2[i][j] * $signed(cam_s2[j][CAM_W-1:CAM_LO_W]);
				end
			end

			carry_s4 <= carry_s3;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s4[i][j] <= ($signed(PP_W'(phi_s3[i][j])) <<< CAM_LO_W)
						+ PP_W'(plo_s3[i][j]);
				end
			end

			carry_s5 <= carry_s4;
			for (int i = 0; i < 3; i++) begin
				wr_s5[i] <= WR_W'(acc[i] >>> RAY_SHIFT);
			end
		end
	end

	assign v_out     = v_s5;
	assign ray.wr_n  = wr_s5[0];
	assign ray.wr_e  = wr_s5[1];
	assign ray.wr_z  = wr_s5[2];
	assign ray.carry = carry_s5;

endmodule

`default_nettype wire

@@ hw/rtl/bgp_scale.sv @@
// Status decision and numerators rn*alt, re*alt for the divider (three stages).
`default_nettype none

module bgp_scale
	import bgp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             v_in,
	input  wire ray_t             ray,
	output logic                  v_out,
	output logic [NUM_W-1:0]      num_n,
	output logic [NUM_W-1:0]      num_e,
	output logic [DEN_W-1:0]      den,
	output div_side_t             side
);

	logic v_s6, v_s7, v_s8;

	status_t          status_s6, status_s7;
	logic [MAG_W-1:0] mag_n_s6, mag_e_s6;
	logic             neg_n_s6, neg_e_s6, neg_n_s7, neg_e_s7;
	logic [DEN_W-1:0] den_s6, den_s7, den_s8;
	carry_t           carry_s6, carry_s7;

	logic [MLO_W+ALT_W-1:0] lo_n_s7, lo_e_s7;
	logic [MHI_W+ALT_W-1:0] hi_n_s7, hi_e_s7;

	logic [NUM_W-1:0] num_n_s8, num_e_s8;
	div_side_t        side_s8;

	status_t st;

	always_comb begin
		if (ray.carry.alt == '0) begin
			st = ST_BAD_ALT;
		end else if (ray.wr_z == '0) begin
			st = ST_PARALLEL;
		end else if (ray.wr_z[WR_W-1]) begin
			st = ST_UPWARD;
		end else begin
			st = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s6 <= v_in;
			v_s7 <= v_s6;
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s6 <= st;
			neg_n_s6  <= ray.wr_n[WR_W-1];
			neg_e_s6  <= ray.wr_e[WR_W-1];
			mag_n_s6  <= ray.wr_n[WR_W-1] ? MAG_W'(-ray.wr_n) : MAG_W'(ray.wr_n);
			mag_e_s6  <= ray.wr_e[WR_W-1] ? MAG_W'(-ray.wr_e) : MAG_W'(ray.wr_e);
			den_s6    <= DEN_W'(ray.wr_z);
			carry_s6  <= ray.carry;

			status_s7 <= status_s6;
			neg_n_s7  <= neg_n_s6;
			neg_e_s7  <= neg_e_s6;
			den_s7    <= den_s6;
			carry_s7  <= carry_s6;
			lo_n_s7   <= mag_n_s6[MLO_W-1:0] * carry_s6.alt;
			hi_n_s7   <= mag_n_s6[MAG_W-1:MLO_W] * carry_s6.alt;
			lo_e_s7   <= mag_e_s6[MLO_W-1:0] * carry_s6.alt;
			hi_e_s7   <= mag_e_s6[MAG_W-1:MLO_W] * carry_s6.alt;

			// half the divisor folded in for round-half-away on the magnitude
			num_n_s8 <= (NUM_W'(hi_n_s7) << MLO_W) + NUM_W'(lo_n_s7) + NUM_W'(den_s7 >> 1);
			num_e_s8 <= (NUM_W'(hi_e_s7) << MLO_W) + NUM_W'(lo_e_s7) + NUM_W'(den_s7 >> 1);
			den_s8   <= den_s7;
			side_s8  <= '{status: status_s7, neg_n: neg_n_s7, neg_e: neg_e_s7,
				cam_n: carry_s7.cam_n, cam_e: carry_s7.cam_e,
				down: OUT_W'(carry_s7.cam_d) + OUT_W'(carry_s7.alt)};
		end
	end

	assign v_out = v_s8;
	assign num_n = num_n_s8;
	assign num_e = num_e_s8;
	assign den   = den_s8;
	assign side  = side_s8;

endmodule

`default_nettype wire

@@ hw/rtl/bgp_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, north and east lanes.
`default_nettype none

module bgp_div
	import bgp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             adv,
	input  wire logic             v_in,
	input  wire logic [NUM_W-1:0] num_n,
	input  wire logic [NUM_W-1:0] num_e,
	input  wire logic [DEN_W-1:0] den,
	input  wire div_side_t        side,
	output logic                  v_out,
	output logic [NUM_W-1:0]      q_n,
	output logic [NUM_W-1:0]      q_e,
	output div_side_t             side_out
);

	// wrk holds unconsumed dividend bits on top, quotient bits shift in below
	typedef struct packed {
		logic [DEN_W-1:0] rem;
		logic [NUM_W-1:0] wrk;
	} lane_t;

	function automatic lane_t div_step(input logic [DEN_W-1:0] rem,
			input logic [NUM_W-1:0] wrk, input logic [DEN_W-1:0] d);
		logic [DEN_W:0] t;
		lane_t r;
		t = {rem, wrk[NUM_W-1]};
		r.wrk = {wrk[NUM_W-2:0], 1'b0};
		if (t >= {1'b0, d}) begin
			r.rem    = DEN_W'(t - {1'b0, d});
			r.wrk[0] = 1'b1;
		end else begin
			r.rem = DEN_W'(t);
		end
		return r;
	endfunction

	logic             v_s    [NUM_W];
	lane_t            ln_s   [NUM_W];
	lane_t            le_s   [NUM_W];
	logic [DEN_W-1:0] den_s  [NUM_W];
	div_side_t        side_s [NUM_W];

	lane_t nxt_n [NUM_W];
	lane_t nxt_e [NUM_W];

	always_comb begin
		nxt_n[0] = div_step('0, num_n, den);
		nxt_e[0] = div_step('0, num_e, den);
		for (int k = 1; k < NUM_W; k++) begin
			nxt_n[k] = div_step(ln_s[k-1].rem, ln_s[k-1].wrk, den_s[k-1]);
			nxt_e[k] = div_step(le_s[k-1].rem, le_s[k-1].wrk, den_s[k-1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_W; k++) begin
				v_s[k] <= 1'b0;
			end
		end else if (adv) begin
			v_s[0] <= v_in;
			for (int k = 1; k < NUM_W; k++) begin
				v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			den_s[0]  <= den;
			side_s[0] <= side;
			for (int k = 1; k < NUM_W; k++) begin
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
			for (int k = 0; k < NUM_W; k++) begin
				ln_s[k] <= nxt_n[k];
				le_s[k] <= nxt_e[k];
			end
		end
	end

	assign v_out    = v_s[NUM_W-1];
	assign q_n      = ln_s[NUM_W-1].wrk;
	assign q_e      = le_s[NUM_W-1].wrk;
	assign side_out = side_s[NUM_W-1];

endmodule

`default_nettype wire

@@ hw/rtl/bgp_obuf.sv @@
// Final sign, offset add and saturation into a two-entry output queue.
`default_nettype none

module bgp_obuf
	import bgp_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             v_in,
	input  wire logic [NUM_W-1:0] q_n,
	input  wire logic [NUM_W-1:0] q_e,
	input  wire div_side_t        side,
	output logic                  adv,
	output logic                  rsp_valid,
	input  wire logic             rsp_ready,
	output out_item_t             rsp
);

	localparam int SUM_W = NUM_W + 2;

	function automatic logic signed [OUT_W-1:0] place(input logic signed [POS_W-1:0] cam,
			input logic [NUM_W-1:0] q, input logic neg);
		logic signed [SUM_W-1:0] off;
		logic signed [SUM_W-1:0] s;
		logic signed [OUT_W-1:0] r;
		off = $signed({2'b00, q});
		if (neg) begin
			off = -off;
		end
		s = off + SUM_W'(cam);
		if (s[SUM_W-1:OUT_W-1] == '0 || s[SUM_W-1:OUT_W-1] == '1) begin
			r = s[OUT_W-1:0];
		end else if (s[SUM_W-1]) begin
			r = {1'b1, {(OUT_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(OUT_W-1){1'b1}}};
		end
		return r;
	endfunction

	out_item_t  ent_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push, pop;
	out_item_t  nxt;

	assign adv       = (cnt_q != 2'd2) || rsp_ready;
	assign push      = adv && v_in;
	assign rsp_valid = (cnt_q != 2'd0);
	assign pop       = rsp_valid && rsp_ready;
	assign rsp       = ent_q[rd_q];

	always_comb begin
		nxt        = '0;
		nxt.status = side.status;
		if (side.status == ST_OK) begin
			nxt.point_north_mm = place(side.cam_n, q_n, side.neg_n);
			nxt.point_east_mm  = place(side.cam_e, q_e, side.neg_e);
			nxt.point_down_mm  = side.down;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (pop) begin
				rd_q <= !rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= nxt;
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("output queue count out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |-> cnt_q == 2'd2)
		else $error("pipeline stalled with room in output queue");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> cnt_q == $past(cnt_q) + 2'd1)
		else $error("output queue lost a transaction");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.point_north_mm == '0
			&& rsp.point_east_mm == '0 && rsp.point_down_mm == '0)
		else $error("invalid result carries nonzero point");

endmodule

`default_nettype wire

@@ hw/rtl/pixel_ground_plane_backprojection.sv @@
// Top level: config registers and the back-projection pipeline.
//
//  channel  | signals                         | handshake
//  ---------+---------------------------------+------------------------------
//  req      | req_valid, req_ready, req       | valid/ready, in_item_t
//  rsp      | rsp_valid, rsp_ready, rsp       | valid/ready, out_item_t
//  cfg      | cfg_we, cfg_index, cfg_data     | write on cfg_we, no stall
//
// One pixel per cycle sustained while the pipeline is not halted (see below). Stages:
// five ray stages, three scaling stages, one divider stage per quotient bit, one
// output stage. The divider depth sets the latency.
// Reset restores the four registers to their defaults and empties the pipeline.
// The pipeline halts as a whole only while the two-entry output queue is full and
// rsp_ready is low; req_ready is low exactly then.
`default_nettype none

module pixel_ground_plane_backprojection
	import bgp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 req_valid,
	output logic                      req_ready,
	input  wire in_item_t             req,
	output logic                      rsp_valid,
	input  wire logic                 rsp_ready,
	output out_item_t                 rsp
);

	logic [CFG_W-1:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

	logic             adv;
	logic             v_ray, v_scl, v_div;
	ray_t             ray;
	logic [NUM_W-1:0] num_n, num_e, q_n, q_e;
	logic [DEN_W-1:0] den;
	div_side_t        side_scl, side_div;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_FOCAL_X:  focal_x_q  <= cfg_data;
				REG_FOCAL_Y:  focal_y_q  <= cfg_data;
				REG_CENTER_X: center_x_q <= cfg_data;
				REG_CENTER_Y: center_y_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign req_ready = adv;

	bgp_ray u_ray (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (req_valid),
		.item     (req),
		.focal_x  (focal_x_q),
		.focal_y  (focal_y_q),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.v_out    (v_ray),
		.ray      (ray)
	);

	bgp_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.adv    (adv),
		.v_in   (v_ray),
		.ray    (ray),
		.v_out  (v_scl),
		.num_n  (num_n),
		.num_e  (num_e),
		.den    (den),
		.side   (side_scl)
	);

	bgp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.v_in     (v_scl),
		.num_n    (num_n),
		.num_e    (num_e),
		.den      (den),
		.side     (side_scl),
		.v_out    (v_div),
		.q_n      (q_n),
		.q_e      (q_e),
		.side_out (side_div)
	);

	bgp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.v_in      (v_div),
		.q_n       (q_n),
		.q_e       (q_e),
		.side      (side_div),
		.adv       (adv),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ verif/bgp_checker.sv @@
// Checker: predicts ground points from observed request transactions and compares responses.
`timescale 1ns / 100ps
`default_nettype none

module bgp_checker
	import bgp_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 req_valid,
	input  wire logic                 req_ready,
	input  wire in_item_t             req,
	input  wire logic                 rsp_valid,
	input  wire logic                 rsp_ready,
	input  wire out_item_t            rsp,
	output int                        fail_count,
	output int                        pending,
	output int                        rsp_count,
	output int                        st_seen [4]
);

	logic [CFG_W-1:0] fx_q, fy_q, cx_q, cy_q;
	out_item_t ground_points_q[$];

	function automatic longint floor_sh(longint v, int k);
		if (v >= 0)
			return v >>> k;
		return -((-v - 1) >>> k) - 1;
	endfunction

	function automatic longint round_sh(longint v, int k);
		return floor_sh(v + (longint'(1) << (k - 1)), k);
	endfunction

	function automatic longint sat32(longint v);
		if (v > 64'sd2147483647)
			return 64'sd2147483647;
		if (v < -64'sd2147483648)
			return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint div_round(longint r, longint alt, longint den);
		longint num, mag, q;
		num = r * alt;
		mag = (num < 0) ? -num : num;
		q = (mag + den / 2) / den;
		return (num < 0) ? -q : q;
	endfunction

	function automatic out_item_t project_pixel(in_item_t it);
		longint w, x, y, z, fx, fy, alt, acc;
		longint cam[3], wr[3];
		longint m[3][3];
		out_item_t o;
		w = longint'(it.rot_w); x = longint'(it.rot_x);
		y = longint'(it.rot_y); z = longint'(it.rot_z);
		fx = longint'(fx_q); fy = longint'(fy_q); alt = longint'(it.altitude_mm);
		cam[0] = (longint'(it.pixel_col) * 256 - longint'(cx_q)) * fy;
		cam[1] = (longint'(it.pixel_row) * 256 - longint'(cy_q)) * fx;
		cam[2] = fx * fy;
		m[0][0] = w*w + x*x - y*y - z*z;
		m[0][1] = 2 * (x*y - w*z);
		m[0][2] = 2 * (x*z + w*y);
		m[1][0] = 2 * (x*y + w*z);
		m[1][1] = w*w - x*x + y*y - z*z;
		m[1][2] = 2 * (y*z - w*x);
		m[2][0] = 2 * (x*z - w*y);
		m[2][1] = 2 * (y*z + w*x);
		m[2][2] = w*w - x*x - y*y + z*z;
		for (int i = 0; i < 3; i++) begin
			acc = 0;
			for (int j = 0; j < 3; j++)
				acc += round_sh(m[i][j], MAT_SHIFT) * cam[j];
			wr[i] = round_sh(acc, RAY_SHIFT);
		end
		o = '0;
		if (alt == 0)
			o.status = ST_BAD_ALT;
		else if (wr[2] == 0)
			o.status = ST_PARALLEL;
		else if (wr[2] < 0)
			o.status = ST_UPWARD;
		else begin
			o.status = ST_OK;
			o.point_north_mm = 32'(sat32(longint'(it.cam_north_mm) + div_round(wr[0], alt, wr[2])));
			o.point_east_mm = 32'(sat32(longint'(it.cam_east_mm) + div_round(wr[1], alt, wr[2])));
			o.point_down_mm = 32'(longint'(it.cam_down_mm) + alt);
		end
		return o;
	endfunction

	assign pending = ground_points_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		out_item_t exp_pt;
		if (!arst_n) begin
			fx_q <= FOCAL_X_RST;
			fy_q <= FOCAL_Y_RST;
			cx_q <= CENTER_X_RST;
			cy_q <= CENTER_Y_RST;
			fail_count <= 0;
			rsp_count <= 0;
			for (int i = 0; i < 4; i++)
				st_seen[i] <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FOCAL_X: fx_q <= cfg_data;
					REG_FOCAL_Y: fy_q <= cfg_data;
					REG_CENTER_X: cx_q <= cfg_data;
					REG_CENTER_Y: cy_q <= cfg_data;
					default: ;
				endcase
			end
			if (req_valid && req_ready)
				ground_points_q.push_back(project_pixel(req));
			if (rsp_valid && rsp_ready) begin
				rsp_count <= rsp_count + 1;
				st_seen[rsp.status] <= st_seen[rsp.status] + 1;
				if (ground_points_q.size() == 0) begin
					$error("response transaction with no expectation pending");
					fail_count <= fail_count + 1;
				end else begin
					exp_pt = ground_points_q.pop_front();
					if (rsp != exp_pt)
						fail_count <= fail_count + 1;
					if (rsp.point_north_mm != exp_pt.point_north_mm)
						$error("point_north_mm: expected %0d, got %0d",
							exp_pt.point_north_mm, rsp.point_north_mm);
					if (rsp.point_east_mm != exp_pt.point_east_mm)
						$error("point_east_mm: expected %0d, got %0d",
							exp_pt.point_east_mm, rsp.point_east_mm);
					if (rsp.point_down_mm != exp_pt.point_down_mm)
						$error("point_down_mm: expected %0d, got %0d",
							exp_pt.point_down_mm, rsp.point_down_mm);
					if (rsp.status != exp_pt.status)
						$error("status: expected %0d, got %0d", exp_pt.status, rsp.status);
				end
			end
		end
	end

endmodule

`default_nettype wire

@@ verif/tb_top.sv @@
// Testbench top: stimulus, config sweeps, flow control and verdict for the back-projection block.
`timescale 1ns / 100ps
`default_nettype none

module tb_top;
	import bgp_pkg::*;

	localparam int LATENCY = 9 + NUM_W;

	logic clk, arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;
	logic req_valid, req_ready, rsp_valid, rsp_ready;
	in_item_t req;
	out_item_t rsp;
	int fail_count, pending, rsp_count;
	int st_seen [4];
	int sent;
	bit hold_rsp, rsp_random;

	pixel_ground_plane_backprojection dut (.*);

	bgp_checker u_checker (.*);

	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	initial begin
		#20ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// receiver: random stalls, plus one long hold-off when requested
	initial begin
		int gap;
		bit held;
		rsp_ready = 1'b0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rsp && !held) begin
				held = 1'b1;
				rsp_ready <= 1'b0;
				repeat (300) @(posedge clk);
				rsp_ready <= 1'b1;
			end else if (rsp_random && $urandom_range(0, 3) == 0) begin
				gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
				rsp_ready <= 1'b0;
				repeat (gap) @(posedge clk);
				rsp_ready <= 1'b1;
			end else
				rsp_ready <= 1'b1;
		end
	end

	function automatic logic signed [QUAT_W-1:0] rand_quat_part();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'sd0;
			3: return 16'($urandom);
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	function automatic in_item_t rand_pixel();
		in_item_t it;
		it.pixel_col = PIXEL_BITS'($urandom);
		it.pixel_row = PIXEL_BITS'($urandom);
		it.altitude_mm = ($urandom_range(0, 19) == 0) ? 16'd0 : 16'($urandom);
		it.cam_north_mm = POS_W'($urandom);
		it.cam_east_mm = POS_W'($urandom);
		it.cam_down_mm = POS_W'($urandom);
		// mostly camera looking down: w near 1 gives rz positive
		if ($urandom_range(0, 3) != 0) begin
			it.rot_w = 16'($signed($urandom_range(12000, 16384)));
			it.rot_x = 16'($signed($urandom_range(0, 6000)) - 3000);
			it.rot_y = 16'($signed($urandom_range(0, 6000)) - 3000);
			it.rot_z = 16'($signed($urandom_range(0, 32768)) - 16384);
		end else begin
			it.rot_w = rand_quat_part();
			it.rot_x = rand_quat_part();
			it.rot_y = rand_quat_part();
			it.rot_z = rand_quat_part();
		end
		return it;
	endfunction

	task automatic send_pixel(input in_item_t it, input bit gaps);
		int gap;
		if (gaps && $urandom_range(0, 3) == 0) begin
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= it;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sent++;
	endtask

	task automatic wait_drained();
		req_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_camera(input logic [CFG_W-1:0] fx, fy, cx, cy);
		write_reg(REG_FOCAL_X, fx);
		write_reg(REG_FOCAL_Y, fy);
		write_reg(REG_CENTER_X, cx);
		write_reg(REG_CENTER_Y, cy);
		@(posedge clk);
	endtask

	initial begin
		in_item_t it;
		logic [CFG_W-1:0] cams [5][4];
		cams = '{'{20'd128000, 20'd128000, 20'd81920, 20'd61440},
			'{20'd256, 20'd256, 20'd0, 20'd0},
			'{20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF},
			'{20'd0, 20'd300000, 20'd524288, 20'd0},
			'{20'd200000, 20'd256, 20'd0, 20'hFFFFF}};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_FOCAL_X;
		cfg_data = '0;
		req_valid = 1'b0;
		req = '0;
		sent = 0;
		hold_rsp = 1'b0;
		rsp_random = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: reset config, identity and extreme poses, special cases
		for (int k = 0; k < 20; k++) begin
			it = '0;
			it.altitude_mm = (k == 1) ? 16'd0 : ((k % 3 == 0) ? 16'hFFFF : 16'(1000 + k));
			it.pixel_col = (k[0]) ? 12'hFFF : 12'd0;
			it.pixel_row = (k[1]) ? 12'hFFF : 12'd0;
			it.rot_w = 16'sd16384;
			it.cam_north_mm = (k[2]) ? 24'sh7FFFFF : 24'sh800000;
			it.cam_east_mm = (k[3]) ? 24'sh800000 : 24'sh7FFFFF;
			it.cam_down_mm = (k[0]) ? 24'sh7FFFFF : 24'sh800000;
			case (k)
				2: it.rot_w = 16'sd0;                   // zero quaternion: parallel
				3: begin it.rot_w = 16'sd0; it.rot_x = 16'sd16384; end  // flips: upward
				4: begin it.rot_w = -16'sd16384; end
				5: begin it.rot_w = 16'sd11585; it.rot_y = 16'sd11585; end   // horizon
				6: begin it.rot_w = 16'sd16384; it.rot_x = 16'sd16384;
					it.rot_y = 16'sd16384; it.rot_z = 16'sd16384; end
				7: begin it.rot_w = 16'sd16000; it.rot_x = 16'sd3000; end // big offset
				8: begin it.rot_w = -16'sd16384; it.rot_x = -16'sd16384;
					it.rot_y = -16'sd16384; it.rot_z = -16'sd16384; end
				default: ;
			endcase
			send_pixel(it, 1'b0);
		end
		wait_drained();

		rsp_random = 1'b1;
		for (int c = 0; c < 5; c++) begin
			set_camera(cams[c][0], cams[c][1], cams[c][2], cams[c][3]);
			for (int n = 0; n < 150; n++)
				send_pixel(rand_pixel(), 1'b1);
			if (c == 1) begin
				// back-pressure: receiver stalls while sender keeps pushing past capacity
				hold_rsp = 1'b1;
				for (int n = 0; n < 100; n++)
					send_pixel(rand_pixel(), 1'b0);
				hold_rsp = 1'b0;
			end
			wait_drained();
		end
		for (int c = 0; c < 3; c++) begin
			set_camera(20'($urandom_range(256, 1048575)), 20'($urandom_range(256, 1048575)),
				20'($urandom), 20'($urandom));
			for (int n = 0; n < 160; n++)
				send_pixel(rand_pixel(), 1'b1);
			wait_drained();
		end

		$display("Sent %0d pixels over 9 camera settings; %0d responses checked.", sent, rsp_count);
		$display("Status mix: ok %0d, bad altitude %0d, parallel %0d, upward %0d.",
			st_seen[0], st_seen[1], st_seen[2], st_seen[3]);
		if (fail_count == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire

@@ filelist.f @@
hw/rtl/bgp_pkg.sv
hw/rtl/bgp_ray.sv
hw/rtl/bgp_scale.sv
hw/rtl/bgp_div.sv
hw/rtl/bgp_obuf.sv
hw/rtl/pixel_ground_plane_backprojection.sv
verif/bgp_checker.sv
verif/tb_top.sv
